>>> rtl/core/bca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

    // map geometry
    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    // configuration registers
    localparam int CFG_W    = 11;
    localparam int CMP_W    = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_LARGE_END  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SMALL_END  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] LARGE_END_RST  = CFG_W'(512);
    localparam logic [CFG_W-1:0] SMALL_END_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] DATA_COUNT_RST = CFG_W'(1024);

    // request codes
    localparam logic MODE_FIND = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    localparam logic [1:0] SEL_LARGE = 2'd0;
    localparam logic [1:0] SEL_SMALL = 2'd1;
    localparam logic [1:0] SEL_DATA  = 2'd2;

    // result codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_HOLDS   = 2'd2;
    localparam logic [1:0] ST_NOSPACE = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] large_end;
        logic [CFG_W-1:0] small_end;
        logic [CFG_W-1:0] data_count;
    } cfg_t;

    typedef struct packed {
        logic             re;
        logic             we;
        logic [IDX_W-1:0] addr;
        logic             wdata;
    } ram_req_t;

    function automatic logic [CNT_W-1:0] clamp_end(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (CMP_W'(v) > CMP_W'(ENTRIES))
            r = CNT_W'(ENTRIES);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bca_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bca_map_ram
(
    input  wire logic              clk,
    input  wire bca_pkg::ram_req_t req,
    output logic                   rdata
);

    logic map_mem [bca_pkg::ENTRIES];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            map_mem[req.addr] <= req.wdata;
        if (req.re)
            rdata_reg <= map_mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bca_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bca_cfg_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bca_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bca_pkg::APB_DW-1:0]   pwdata,
    output logic      [bca_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output bca_pkg::cfg_t                     cfg
);

    bca_pkg::cfg_t cfg_reg;
    bca_pkg::cfg_t cfg_next;
    logic [bca_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[bca_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                bca_pkg::REG_LARGE_END:  cfg_next.large_end  = pwdata[bca_pkg::CFG_W-1:0];
                bca_pkg::REG_SMALL_END:  cfg_next.small_end  = pwdata[bca_pkg::CFG_W-1:0];
                bca_pkg::REG_DATA_COUNT: cfg_next.data_count = pwdata[bca_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bca_pkg::REG_LARGE_END:  prdata = bca_pkg::APB_DW'(cfg_reg.large_end);
            bca_pkg::REG_SMALL_END:  prdata = bca_pkg::APB_DW'(cfg_reg.small_end);
            bca_pkg::REG_DATA_COUNT: prdata = bca_pkg::APB_DW'(cfg_reg.data_count);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.large_end  <= bca_pkg::LARGE_END_RST;
            cfg_reg.small_end  <= bca_pkg::SMALL_END_RST;
            cfg_reg.data_count <= bca_pkg::DATA_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/bca_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module bca_engine
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bca_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic [1:0]                 map_select,
    input  wire logic [bca_pkg::IDX_W-1:0]  first_entry,
    input  wire logic [bca_pkg::CNT_W-1:0]  run_length,
    input  wire logic                       new_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [1:0]                 status,
    output logic      [bca_pkg::IDX_W-1:0]  position,
    output bca_pkg::ram_req_t               inode_req,
    output bca_pkg::ram_req_t               data_req,
    input  wire logic                       inode_rdata,
    input  wire logic                       data_rdata
);

    localparam int IDX_W = bca_pkg::IDX_W;
    localparam int CNT_W = bca_pkg::CNT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_FIND   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] clr_reg, clr_next;
    logic             mode_reg, mode_next;
    logic [1:0]       sel_reg, sel_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             val_reg, val_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic             dv_reg, dv_next;
    logic [CNT_W-1:0] dt_idx_reg, dt_idx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_pos_reg, res_pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_pos_reg, out_pos_next;

    logic [CNT_W-1:0] le, se, dc;
    logic             issue;
    logic             bit_rd;
    logic [CNT_W:0]   set_end;
    logic [CNT_W-1:0] run_inc;
    logic [CNT_W-1:0] found_pos;
    bca_pkg::ram_req_t req;

    assign le = bca_pkg::clamp_end(cfg.large_end);
    assign se = bca_pkg::clamp_end(cfg.small_end);
    assign dc = bca_pkg::clamp_end(cfg.data_count);

    assign issue     = (rd_idx_reg < end_reg);
    assign bit_rd    = (sel_reg == bca_pkg::SEL_DATA) ? data_rdata : inode_rdata;
    assign set_end   = (CNT_W + 1)'(first_reg) + (CNT_W + 1)'(len_reg);
    assign run_inc   = run_reg + CNT_W'(1);
    assign found_pos = dt_idx_reg + CNT_W'(1) - len_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        mode_next       = mode_reg;
        sel_next        = sel_reg;
        first_next      = first_reg;
        len_next        = len_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rd_idx_next     = rd_idx_reg;
        end_next        = end_reg;
        dv_next         = 1'b0;
        dt_idx_next     = dt_idx_reg;
        run_next        = run_reg;
        wr_idx_next     = wr_idx_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;

        req       = '0;
        inode_req = '0;
        data_req  = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                req.we    = 1'b1;
                req.addr  = clr_reg[IDX_W-1:0];
                req.wdata = 1'b0;
                clr_next  = clr_reg + CNT_W'(1);
                if (clr_reg == CNT_W'(bca_pkg::ENTRIES - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    sel_next   = map_select;
                    first_next = first_entry;
                    len_next   = run_length;
                    val_next   = new_value;
                    unique case (map_select)
                        bca_pkg::SEL_LARGE:
                        begin
                            lo_next = '0;
                            hi_next = le;
                        end
                        bca_pkg::SEL_SMALL:
                        begin
                            lo_next = le;
                            hi_next = (se < le) ? le : se;
                        end
                        default:
                        begin
                            lo_next = '0;
                            hi_next = dc;
                        end
                    endcase
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_pos_next = '0;
                run_next     = '0;
                if (len_reg == '0 || !(sel_reg == bca_pkg::SEL_LARGE ||
                    sel_reg == bca_pkg::SEL_SMALL || sel_reg == bca_pkg::SEL_DATA))
                begin
                    res_status_next = bca_pkg::ST_RANGE;
                    state_next      = S_RESULT;
                end
                else if (mode_reg == bca_pkg::MODE_FIND)
                begin
                    rd_idx_next = lo_reg;
                    end_next    = hi_reg;
                    state_next  = S_FIND;
                end
                else if (CNT_W'(first_reg) < lo_reg || set_end > (CNT_W + 1)'(hi_reg))
                begin
                    res_status_next = bca_pkg::ST_RANGE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    rd_idx_next = CNT_W'(first_reg);
                    end_next    = set_end[CNT_W-1:0];
                    state_next  = S_CHECK;
                end
            end

            S_FIND:
            begin
                req.re      = issue;
                req.addr    = rd_idx_reg[IDX_W-1:0];
                dv_next     = issue;
                dt_idx_next = rd_idx_reg;
                if (issue)
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (dv_reg)
                begin
                    if (!bit_rd)
                    begin
                        run_next = run_inc;
                        if (run_inc == len_reg)
                        begin
                            res_status_next = bca_pkg::ST_OK;
                            res_pos_next    = found_pos[IDX_W-1:0];
                            dv_next         = 1'b0;
                            state_next      = S_RESULT;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (!issue)
                begin
                    // nothing in flight and region exhausted
                    res_status_next = bca_pkg::ST_NOSPACE;
                    state_next      = S_RESULT;
                end
            end

            S_CHECK:
            begin
                req.re      = issue;
                req.addr    = rd_idx_reg[IDX_W-1:0];
                dv_next     = issue;
                dt_idx_next = rd_idx_reg;
                if (issue)
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (dv_reg)
                begin
                    if (bit_rd == val_reg)
                    begin
                        res_status_next = bca_pkg::ST_HOLDS;
                        dv_next         = 1'b0;
                        state_next      = S_RESULT;
                    end
                end
                else if (!issue)
                begin
                    wr_idx_next = CNT_W'(first_reg);
                    state_next  = S_WRITE;
                end
            end

            S_WRITE:
            begin
                req.we      = 1'b1;
                req.addr    = wr_idx_reg[IDX_W-1:0];
                req.wdata   = val_reg;
                wr_idx_next = wr_idx_reg + CNT_W'(1);
                if (wr_idx_next == end_reg)
                begin
                    res_status_next = bca_pkg::ST_OK;
                    res_pos_next    = first_reg;
                    state_next      = S_RESULT;
                end
            end

            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_CLEAR)
        begin
            inode_req = req;
            data_req  = req;
        end
        else if (sel_reg == bca_pkg::SEL_DATA)
        begin
            data_req = req;
        end
        else
        begin
            inode_req = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        sel_reg        <= sel_next;
        first_reg      <= first_next;
        len_reg        <= len_next;
        val_reg        <= val_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        rd_idx_reg     <= rd_idx_next;
        end_reg        <= end_next;
        dt_idx_reg     <= dt_idx_next;
        run_reg        <= run_next;
        wr_idx_reg     <= wr_idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign position  = out_pos_reg;

endmodule

`default_nettype wire

>>> rtl/core/bytemap_contiguous_allocator.sv
// Channel   Handshake                      Payload
// config    psel penable pwrite pready     paddr pwdata prdata
// request   in_valid in_ready              mode map_select first_entry run_length new_value
// result    out_valid out_ready            status position
//
// After reset both maps are swept to zero, one entry per cycle over all 1024 entries;
// no request is taken during the sweep, configuration writes are.
// A find reads the region entry by entry from its start up to the end of the first fitting
// run, through the single read port of the map. A set makes a read pass over the run, then,
// if no entry already holds the new value, a write pass. A finished result waits in the
// output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module bytemap_contiguous_allocator
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bca_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bca_pkg::APB_DW-1:0]    pwdata,
    output logic      [bca_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [1:0]                    map_select,
    input  wire logic [bca_pkg::IDX_W-1:0]     first_entry,
    input  wire logic [bca_pkg::CNT_W-1:0]     run_length,
    input  wire logic                          new_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [1:0]                    status,
    output logic      [bca_pkg::IDX_W-1:0]     position
);

    bca_pkg::cfg_t     cfg;
    bca_pkg::ram_req_t inode_req;
    bca_pkg::ram_req_t data_req;
    logic              inode_rdata;
    logic              data_rdata;

    bca_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bca_map_ram u_inode_map
    (
        .clk   (clk),
        .req   (inode_req),
        .rdata (inode_rdata)
    );

    bca_map_ram u_data_map
    (
        .clk   (clk),
        .req   (data_req),
        .rdata (data_rdata)
    );

    bca_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .map_select  (map_select),
        .first_entry (first_entry),
        .run_length  (run_length),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .inode_req   (inode_req),
        .data_req    (data_req),
        .inode_rdata (inode_rdata),
        .data_rdata  (data_rdata)
    );

endmodule

`default_nettype wire

>>> tb/bytemap_contiguous_allocator_test.sv
`timescale 1ns / 1ps

module bytemap_contiguous_allocator_test;
    import bca_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 50;
    localparam int N_PHASES    = 9;

    localparam logic [1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic             op;
        logic [1:0]       sel;
        logic [IDX_W-1:0] start;
        logic [CNT_W-1:0] len;
        logic             val;
        logic             known;
        logic [1:0]       known_status;
        logic [IDX_W-1:0] known_pos;
    } alloc_request_t;

    typedef struct packed {
        logic [1:0]       st;
        logic [IDX_W-1:0] pos;
    } alloc_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    wire  [APB_DW-1:0]  prdata;
    wire                pready;
    logic               in_valid = 1'b0;
    wire                in_ready;
    logic               mode = MODE_FIND;
    logic [1:0]         map_select = SEL_LARGE;
    logic [IDX_W-1:0]   first_entry = '0;
    logic [CNT_W-1:0]   run_length = '0;
    logic               new_value = 1'b0;
    wire                out_valid;
    logic               out_ready = 1'b1;
    wire  [1:0]         status;
    wire  [IDX_W-1:0]   position;

    // typed-in expectation travelling with the request
    logic               req_known = 1'b0;
    logic [1:0]         req_known_status = ST_OK;
    logic [IDX_W-1:0]   req_known_pos = '0;

    // own copy of the maps and registers
    bit                 alloc_map [2][ENTRIES];
    logic [CFG_W-1:0]   large_end_q = LARGE_END_RST;
    logic [CFG_W-1:0]   small_end_q = SMALL_END_RST;
    logic [CFG_W-1:0]   data_count_q = DATA_COUNT_RST;
    alloc_result_t      pending_results [$];

    int unsigned        requests_sent = 0;
    int unsigned        requests_taken = 0;
    int unsigned        results_seen = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;
    bit                 no_idle = 1'b0;
    bit                 long_hold_done = 1'b0;

    // default registers: large [0,512), small [512,1024), data [0,1024)
    alloc_request_t directed_table [25] = '{
        '{MODE_FIND, SEL_LARGE, 10'd0,    11'd1,    1'b0, 1'b1, ST_OK,      10'd0},
        '{MODE_FIND, SEL_SMALL, 10'd0,    11'd1,    1'b0, 1'b1, ST_OK,      10'd512},
        '{MODE_FIND, SEL_DATA,  10'd0,    11'd1024, 1'b0, 1'b1, ST_OK,      10'd0},
        '{MODE_FIND, SEL_DATA,  10'd0,    11'd1025, 1'b0, 1'b1, ST_NOSPACE, 10'd0},
        '{MODE_FIND, SEL_LARGE, 10'd1023, 11'd2047, 1'b1, 1'b1, ST_NOSPACE, 10'd0},
        '{MODE_FIND, SEL_LARGE, 10'd0,    11'd0,    1'b0, 1'b1, ST_RANGE,   10'd0},
        '{MODE_FIND, SEL_NONE,  10'd0,    11'd1,    1'b0, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_NONE,  10'd0,    11'd1,    1'b1, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_LARGE, 10'd0,    11'd0,    1'b1, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_LARGE, 10'd0,    11'd1,    1'b1, 1'b1, ST_OK,      10'd0},
        '{MODE_SET,  SEL_LARGE, 10'd0,    11'd1,    1'b1, 1'b1, ST_HOLDS,   10'd0},
        '{MODE_SET,  SEL_LARGE, 10'd511,  11'd2,    1'b1, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_SMALL, 10'd0,    11'd1,    1'b1, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_SMALL, 10'd1023, 11'd1,    1'b1, 1'b1, ST_OK,      10'd1023},
        '{MODE_FIND, SEL_SMALL, 10'd0,    11'd512,  1'b0, 1'b1, ST_NOSPACE, 10'd0},
        '{MODE_FIND, SEL_SMALL, 10'd0,    11'd511,  1'b0, 1'b1, ST_OK,      10'd512},
        '{MODE_FIND, SEL_LARGE, 10'd0,    11'd1,    1'b0, 1'b1, ST_OK,      10'd1},
        '{MODE_SET,  SEL_DATA,  10'd0,    11'd1024, 1'b1, 1'b1, ST_OK,      10'd0},
        '{MODE_FIND, SEL_DATA,  10'd0,    11'd1,    1'b0, 1'b1, ST_NOSPACE, 10'd0},
        '{MODE_SET,  SEL_DATA,  10'd1023, 11'd1025, 1'b1, 1'b1, ST_RANGE,   10'd0},
        '{MODE_SET,  SEL_DATA,  10'd0,    11'd1024, 1'b0, 1'b1, ST_OK,      10'd0},
        '{MODE_SET,  SEL_DATA,  10'd5,    11'd3,    1'b0, 1'b1, ST_HOLDS,   10'd0},
        '{MODE_SET,  SEL_LARGE, 10'd0,    11'd1,    1'b0, 1'b1, ST_OK,      10'd0},
        '{MODE_SET,  SEL_SMALL, 10'd1023, 11'd1,    1'b0, 1'b1, ST_OK,      10'd1023},
        '{MODE_SET,  SEL_DATA,  10'd1023, 11'd1,    1'b1, 1'b1, ST_OK,      10'd1023}
    };

    // large end, small end, data count, requests; -1 draws a random value
    int phase_cfg [N_PHASES][4] = '{
        '{64, 128, 96, 90},
        '{0, 0, 0, 20},
        '{1024, 1024, 1024, 40},
        '{100, 40, 50, 60},
        '{2047, 1500, 2047, 40},
        '{16, 48, 32, 90},
        '{-1, -1, -1, 70},
        '{-1, -1, -1, 70},
        '{512, 1024, 1024, 75}
    };

    bytemap_contiguous_allocator uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .map_select  (map_select),
        .first_entry (first_entry),
        .run_length  (run_length),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position)
    );

    always #5 clk = ~clk;

    function automatic bit region_bounds(input logic [1:0] sel, output int unsigned lo,
                                         output int unsigned hi);
        int unsigned le;
        int unsigned se;
        le = (large_end_q > ENTRIES) ? ENTRIES : large_end_q;
        se = (small_end_q > ENTRIES) ? ENTRIES : small_end_q;
        lo = 0;
        hi = 0;
        case (sel)
            SEL_LARGE: hi = le;
            SEL_SMALL:
            begin
                lo = le;
                hi = (se < le) ? le : se;
            end
            SEL_DATA:  hi = (data_count_q > ENTRIES) ? ENTRIES : data_count_q;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic alloc_result_t predict_alloc(input alloc_request_t r);
        alloc_result_t res;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   run;
        int unsigned   m;
        int unsigned   first;
        int unsigned   len;
        bit            clash;
        res.st = ST_RANGE;
        res.pos = '0;
        first = r.start;
        len = r.len;
        m = (r.sel == SEL_DATA) ? 1 : 0;
        if (len == 0 || !region_bounds(r.sel, lo, hi))
            return res;
        if (r.op == MODE_FIND)
        begin
            res.st = ST_NOSPACE;
            run = 0;
            for (int unsigned i = lo; i < hi; i++)
            begin
                run = alloc_map[m][i] ? 0 : run + 1;
                if (run == len)
                begin
                    res.st = ST_OK;
                    res.pos = IDX_W'(i + 1 - len);
                    break;
                end
            end
        end
        else if (first >= lo && first + len <= hi)
        begin
            clash = 1'b0;
            for (int unsigned i = first; i < first + len; i++)
                if (alloc_map[m][i] == r.val)
                    clash = 1'b1;
            if (clash)
                res.st = ST_HOLDS;
            else
            begin
                for (int unsigned i = first; i < first + len; i++)
                    alloc_map[m][i] = r.val;
                res.st = ST_OK;
                res.pos = r.start;
            end
        end
        return res;
    endfunction

    function automatic int unsigned pick_length(input int unsigned limit);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, (limit < 8) ? limit : 8);
        if (roll < 97)
            return $urandom_range(1, (limit < 64) ? limit : 64);
        return $urandom_range(1, limit);
    endfunction

    function automatic alloc_request_t make_random_request();
        alloc_request_t r;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    span;
        int unsigned    pick;
        int unsigned    len;
        r = '0;
        pick = $urandom_range(0, 99);
        r.sel = 2'($urandom_range(0, 2));
        void'(region_bounds(r.sel, lo, hi));
        span = hi - lo;
        if (pick < 40 && span > 0)
        begin
            // well-formed set inside the region, mostly flipping the entry
            r.op = MODE_SET;
            len = pick_length(span);
            r.start = IDX_W'(lo + $urandom_range(0, span - len));
            r.len = CNT_W'(len);
            if ($urandom_range(0, 9) < 7)
                r.val = !alloc_map[r.sel == SEL_DATA][r.start];
            else
                r.val = 1'($urandom_range(0, 1));
        end
        else if (pick < 75)
        begin
            r.op = MODE_FIND;
            r.len = CNT_W'(pick_length(span + 1));
            r.start = IDX_W'($urandom_range(0, ENTRIES - 1));
            r.val = 1'($urandom_range(0, 1));
        end
        else
        begin
            r.op = 1'($urandom_range(0, 1));
            r.sel = 2'($urandom_range(0, 3));
            r.start = IDX_W'($urandom_range(0, ENTRIES - 1));
            r.len = ($urandom_range(0, 9) == 0) ? '0 : CNT_W'($urandom_range(1, 2047));
            r.val = 1'($urandom_range(0, 1));
        end
        return r;
    endfunction

    task automatic send_request(input alloc_request_t r);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        mode             <= r.op;
        map_select       <= r.sel;
        first_entry      <= r.start;
        run_length       <= r.len;
        new_value        <= r.val;
        req_known        <= r.known;
        req_known_status <= r.known_status;
        req_known_pos    <= r.known_pos;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
    endtask

    // write, then read back the same register; psel stays high for the next access
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_W-1:0] v;
        v = CFG_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DW'(v))
        begin
            $display("%0t register %0d read back: expected %0d, got %0d",
                     $time, idx, v, prdata);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : track_allocations
        alloc_request_t req;
        alloc_result_t  want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got status %0d position %0d",
                             $time, status, position);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t status: expected %0d, got %0d", $time, want.st, status);
                        mismatch_count++;
                    end
                    if (position !== want.pos)
                    begin
                        $display("%0t position: expected %0d, got %0d",
                                 $time, want.pos, position);
                        mismatch_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_LARGE_END:  large_end_q  = pwdata[CFG_W-1:0];
                    REG_SMALL_END:  small_end_q  = pwdata[CFG_W-1:0];
                    REG_DATA_COUNT: data_count_q = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                req = '{mode, map_select, first_entry, run_length, new_value,
                        req_known, req_known_status, req_known_pos};
                want = predict_alloc(req);
                if (req.known)
                begin
                    want.st = req.known_status;
                    want.pos = req.known_pos;
                end
                pending_results.push_back(want);
                requests_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bytemap_contiguous_allocator_test NOT OK");
            $finish;
        end
    end

    initial
    begin : result_sink
        int unsigned gap;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && requests_taken >= 60)
            begin
                // hold off long enough for the block to back up and stall its input
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned large_end;
        int unsigned small_end;
        int unsigned data_count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_table[i])
            send_request(directed_table[i]);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_for_results();
            no_idle = (p == N_PHASES - 1);
            large_end  = (phase_cfg[p][0] < 0) ? $urandom_range(0, 200) : phase_cfg[p][0];
            small_end  = (phase_cfg[p][1] < 0) ? $urandom_range(0, 300) : phase_cfg[p][1];
            data_count = (phase_cfg[p][2] < 0) ? $urandom_range(1, 256) : phase_cfg[p][2];
            write_register(REG_LARGE_END, large_end);
            write_register(REG_SMALL_END, small_end);
            write_register(REG_DATA_COUNT, data_count);
            psel    <= 1'b0;
            penable <= 1'b0;
            for (int k = 0; k < phase_cfg[p][3]; k++)
                send_request(make_random_request());
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bytemap_contiguous_allocator_test OK");
        else
            $display("bytemap_contiguous_allocator_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bca_pkg.sv
rtl/core/bca_map_ram.sv
rtl/core/bca_cfg_regs.sv
rtl/core/bca_engine.sv
rtl/core/bytemap_contiguous_allocator.sv
tb/bytemap_contiguous_allocator_test.sv
